// ----- rtl/core/slc_pkg.sv -----
package slc_pkg;

   // Sprite RAM geometry.
   localparam int STORE_WORDS = 1024;
   localparam int STORE_AW    = $clog2(STORE_WORDS);
   localparam int WORD_AW     = 10;
   localparam int WORD_W      = 16;

   // Command codes on the request channel.
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_NEXT  = 2'd2;

   // Register index on the configuration port, taken from paddr bit 2.
   localparam logic CSR_SCREEN_FLIPPED = 1'b0;

   // List scan limits.
   localparam logic [15:0] END_MARK      = 16'h0180;
   localparam logic [7:0]  LAST_SCAN     = 8'd254;
   localparam logic [7:0]  NO_MARK_ENTRY = 8'd255;

   // Word offsets inside one entry.
   localparam logic [1:0] OFS_CODE = 2'd0;
   localparam logic [1:0] OFS_Y    = 2'd1;
   localparam logic [1:0] OFS_X    = 2'd2;

   // Bits of the y word.
   localparam int Y_FLASH_BIT = 12;
   localparam int Y_FLIPX_BIT = 13;
   localparam int Y_FLIPY_BIT = 14;

   // Priority masks.
   localparam logic [7:0] PRI_LOW  = 8'h00;
   localparam logic [7:0] PRI_MID  = 8'hf0;
   localparam logic [7:0] PRI_HIGH = 8'hf0 | 8'hcc;

   localparam logic [9:0]  PIVOT_X    = 10'd240;
   localparam logic [10:0] PIVOT_Y    = 11'd240;
   localparam logic [8:0]  Y_ADJUST   = 9'd4;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_FETCH,
      SEQ_HAND
   } seq_state_type;

   // One decoded entry handed from the sequencer to the tile emitter.
   typedef struct packed {
      logic              valid;
      logic              skip;
      logic              done;
      logic [WORD_W-1:0] code;
      logic [WORD_W-1:0] y_word;
      logic [WORD_W-1:0] x_word;
   } entry_desc_type;

endpackage

// ----- rtl/core/slc_ram.sv -----
module slc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/slc_seq.sv -----
module slc_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_command,
   input  logic [9:0]             req_word_address,
   input  logic [15:0]            req_word_value,
   input  logic                   req_frame_odd,
   input  logic                   emit_ready,
   output slc_pkg::entry_desc_type desc
);
   import slc_pkg::*;

   seq_state_type state_ff, state_in;

   logic [7:0]        cursor_ff, cursor_in;
   logic              active_ff, active_in;
   logic              parity_ff, parity_in;
   logic              none_ff, none_in;
   logic [7:0]        scan_ff, scan_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [7:0]        chk_idx_ff, chk_idx_in;
   logic [1:0]        fetch_ff, fetch_in;
   logic [WORD_W-1:0] code_ff, code_in;
   logic [WORD_W-1:0] yw_ff, yw_in;
   logic [WORD_W-1:0] xw_ff, xw_in;
   logic              rd_ok_ff, rd_ok_in;

   logic                req_acc;
   logic                ram_we;
   logic [WORD_AW-1:0]  raddr;
   logic [WORD_W-1:0]   rdata;
   logic [WORD_W-1:0]   rd_word;
   logic                scan_hit;
   logic                scan_end;

   assign req_acc = req_valid && !req_stall;
   assign ram_we  = req_acc && (req_command == CMD_WRITE) &&
                    ({3'b000, req_word_address} < 13'(STORE_WORDS));

   // Words above the store read as zero.
   assign rd_ok_in = {3'b000, raddr} < 13'(STORE_WORDS);
   assign rd_word  = rd_ok_ff ? rdata : '0;

   assign scan_hit = chk_valid_ff && (rd_word == END_MARK);
   assign scan_end = chk_valid_ff && (chk_idx_ff == LAST_SCAN);

   slc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (STORE_AW'(req_word_address)),
      .wdata (req_word_value),
      .raddr (STORE_AW'(raddr)),
      .rdata (rdata)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_acc && (req_command == CMD_START)) begin
               state_in = SEQ_SCAN;
            end else if (req_acc && (req_command == CMD_NEXT)) begin
               state_in = active_ff ? SEQ_FETCH : SEQ_HAND;
            end
         end
         SEQ_SCAN: begin
            if (scan_hit || scan_end) begin
               state_in = SEQ_IDLE;
            end
         end
         SEQ_FETCH: begin
            if (fetch_ff == 2'd3) begin
               state_in = SEQ_HAND;
            end
         end
         SEQ_HAND: begin
            if (emit_ready) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = (state_ff != SEQ_IDLE);
      cursor_in    = cursor_ff;
      active_in    = active_ff;
      parity_in    = parity_ff;
      none_in      = none_ff;
      scan_in      = scan_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = scan_ff;
      fetch_in     = fetch_ff;
      code_in      = code_ff;
      yw_in        = yw_ff;
      xw_in        = xw_ff;
      raddr        = {scan_ff, OFS_Y};
      desc         = '0;
      unique case (state_ff)
         SEQ_IDLE: begin
            scan_in  = '0;
            fetch_in = '0;
            if (req_acc && (req_command == CMD_START)) begin
               parity_in = req_frame_odd;
            end
            if (req_acc && (req_command == CMD_NEXT)) begin
               none_in = !active_ff;
            end
         end
         SEQ_SCAN: begin
            raddr        = {scan_ff, OFS_Y};
            scan_in      = scan_ff + 8'd1;
            chk_valid_in = !(scan_hit || scan_end);
            if (scan_hit) begin
               cursor_in = chk_idx_ff;
               active_in = 1'b1;
            end else if (scan_end) begin
               cursor_in = NO_MARK_ENTRY;
               active_in = 1'b1;
            end
         end
         SEQ_FETCH: begin
            raddr    = {cursor_ff, fetch_ff};
            fetch_in = fetch_ff + 2'd1;
            unique case (fetch_ff)
               2'd1:    code_in = rd_word;
               2'd2:    yw_in   = rd_word;
               2'd3:    xw_in   = rd_word;
               default: ;
            endcase
         end
         SEQ_HAND: begin
            desc.valid  = emit_ready;
            desc.done   = none_ff || (cursor_ff == 8'd0);
            desc.skip   = none_ff || (code_ff == '0) ||
                          (yw_ff[Y_FLASH_BIT] && parity_ff);
            desc.code   = code_ff;
            desc.y_word = yw_ff;
            desc.x_word = xw_ff;
            if (emit_ready && !none_ff) begin
               if (cursor_ff == 8'd0) begin
                  active_in = 1'b0;
               end else begin
                  cursor_in = cursor_ff - 8'd1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         cursor_ff    <= '0;
         active_ff    <= 1'b0;
         parity_ff    <= 1'b0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         active_ff    <= active_in;
         parity_ff    <= parity_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      none_ff    <= none_in;
      scan_ff    <= scan_in;
      chk_idx_ff <= chk_idx_in;
      fetch_ff   <= fetch_in;
      code_ff    <= code_in;
      yw_ff      <= yw_in;
      xw_ff      <= xw_in;
      rd_ok_ff   <= rd_ok_in;
   end

`ifndef SYNTH
   a_no_write_when_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != SEQ_IDLE) |-> !ram_we)
      else $error("sprite RAM written outside idle");

   a_start_scans: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_command == CMD_START)) |=> (state_ff == SEQ_SCAN))
      else $error("start transaction did not begin a scan");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> (chk_idx_ff <= LAST_SCAN))
      else $error("scan checked an entry past the last candidate");
`endif

endmodule

// ----- rtl/core/slc_emit.sv -----
module slc_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   screen_flipped,
   input  slc_pkg::entry_desc_type desc,
   output logic                   emit_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_draw,
   output logic [15:0]            rsp_tile_code,
   output logic [4:0]             rsp_colour,
   output logic                   rsp_mirror_x,
   output logic                   rsp_mirror_y,
   output logic signed [9:0]      rsp_pos_x,
   output logic signed [10:0]     rsp_pos_y,
   output logic [7:0]             rsp_pri_mask,
   output logic                   rsp_last_of_entry,
   output logic                   rsp_list_done
);
   import slc_pkg::*;

   // Entry being emitted.
   logic              busy_ff, busy_in;
   logic              skip_ff, skip_in;
   logic              done_ff, done_in;
   logic [2:0]        m_ff, m_in;
   logic [2:0]        multi_ff, multi_in;
   logic [WORD_W-1:0] code_ff, code_in;
   logic              up_ff, up_in;
   logic              flip_ff, flip_in;
   logic [4:0]        colour_ff, colour_in;
   logic              mx_ff, mx_in;
   logic              my_ff, my_in;
   logic [7:0]        pri_ff, pri_in;
   logic [9:0]        px_ff, px_in;
   logic [10:0]       ybase_ff, ybase_in;

   // Result register.
   logic              valid_ff, valid_in;
   logic              draw_ff, draw_in;
   logic [15:0]       tile_ff, tile_in;
   logic [4:0]        ocol_ff, ocol_in;
   logic              omx_ff, omx_in;
   logic              omy_ff, omy_in;
   logic [9:0]        opx_ff, opx_in;
   logic [10:0]       opy_ff, opy_in;
   logic [7:0]        opri_ff, opri_in;
   logic              olast_ff, olast_in;
   logic              odone_ff, odone_in;

   logic        out_load;
   logic [2:0]  multi_new;
   logic [8:0]  ym;
   logic [10:0] ys_ext;
   logic [9:0]  xs_ext;
   logic [10:0] y_off;

   assign emit_ready = !busy_ff;
   assign out_load   = busy_ff && (!valid_ff || !rsp_stall);

   // Column height minus one: 0, 1, 3 or 7.
   assign multi_new = 3'((4'd1 << desc.y_word[10:9]) - 4'd1);
   assign ym        = desc.y_word[8:0] - {2'b00, multi_new, 4'b0000} + Y_ADJUST;
   assign ys_ext    = {{2{ym[8]}}, ym};
   assign xs_ext    = {desc.x_word[8], desc.x_word[8:0]};
   assign y_off     = {4'b0000, m_ff, 4'b0000};

   always_comb begin
      busy_in   = busy_ff;
      skip_in   = skip_ff;
      done_in   = done_ff;
      m_in      = m_ff;
      multi_in  = multi_ff;
      code_in   = code_ff;
      up_in     = up_ff;
      flip_in   = flip_ff;
      colour_in = colour_ff;
      mx_in     = mx_ff;
      my_in     = my_ff;
      pri_in    = pri_ff;
      px_in     = px_ff;
      ybase_in  = ybase_ff;
      if (desc.valid) begin
         busy_in   = 1'b1;
         skip_in   = desc.skip;
         done_in   = desc.done;
         m_in      = desc.skip ? 3'd0 : multi_new;
         multi_in  = multi_new;
         code_in   = desc.code;
         up_in     = desc.y_word[Y_FLIPY_BIT];
         flip_in   = screen_flipped;
         colour_in = desc.x_word[13:9];
         mx_in     = desc.y_word[Y_FLIPX_BIT] ^ screen_flipped;
         my_in     = desc.y_word[Y_FLIPY_BIT] ^ screen_flipped;
         unique case (desc.x_word[15:14])
            2'd0:    pri_in = PRI_LOW;
            2'd1:    pri_in = PRI_MID;
            default: pri_in = PRI_HIGH;
         endcase
         px_in    = screen_flipped ? xs_ext : PIVOT_X - xs_ext;
         ybase_in = screen_flipped ? ys_ext : PIVOT_Y - ys_ext;
      end else if (out_load) begin
         if (m_ff == 3'd0) begin
            busy_in = 1'b0;
         end else begin
            m_in = m_ff - 3'd1;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      draw_in  = draw_ff;
      tile_in  = tile_ff;
      ocol_in  = ocol_ff;
      omx_in   = omx_ff;
      omy_in   = omy_ff;
      opx_in   = opx_ff;
      opy_in   = opy_ff;
      opri_in  = opri_ff;
      olast_in = olast_ff;
      odone_in = odone_ff;
      if (out_load) begin
         valid_in = 1'b1;
         olast_in = (m_ff == 3'd0);
         odone_in = (m_ff == 3'd0) && done_ff;
         if (skip_ff) begin
            draw_in = 1'b0;
            tile_in = '0;
            ocol_in = '0;
            omx_in  = 1'b0;
            omy_in  = 1'b0;
            opx_in  = '0;
            opy_in  = '0;
            opri_in = '0;
         end else begin
            draw_in = 1'b1;
            tile_in = up_ff ? code_ff + {13'd0, m_ff}
                            : code_ff + {13'd0, multi_ff} - {13'd0, m_ff};
            ocol_in = colour_ff;
            omx_in  = mx_ff;
            omy_in  = my_ff;
            opx_in  = px_ff;
            opy_in  = flip_ff ? ybase_ff + y_off : ybase_ff - y_off;
            opri_in = pri_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      skip_ff   <= skip_in;
      done_ff   <= done_in;
      m_ff      <= m_in;
      multi_ff  <= multi_in;
      code_ff   <= code_in;
      up_ff     <= up_in;
      flip_ff   <= flip_in;
      colour_ff <= colour_in;
      mx_ff     <= mx_in;
      my_ff     <= my_in;
      pri_ff    <= pri_in;
      px_ff     <= px_in;
      ybase_ff  <= ybase_in;
      draw_ff   <= draw_in;
      tile_ff   <= tile_in;
      ocol_ff   <= ocol_in;
      omx_ff    <= omx_in;
      omy_ff    <= omy_in;
      opx_ff    <= opx_in;
      opy_ff    <= opy_in;
      opri_ff   <= opri_in;
      olast_ff  <= olast_in;
      odone_ff  <= odone_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_draw          = draw_ff;
   assign rsp_tile_code     = tile_ff;
   assign rsp_colour        = ocol_ff;
   assign rsp_mirror_x      = omx_ff;
   assign rsp_mirror_y      = omy_ff;
   assign rsp_pos_x         = signed'(opx_ff);
   assign rsp_pos_y         = signed'(opy_ff);
   assign rsp_pri_mask      = opri_ff;
   assign rsp_last_of_entry = olast_ff;
   assign rsp_list_done     = odone_ff;

`ifndef SYNTH
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      desc.valid |-> !busy_ff)
      else $error("entry handed over while the previous one is still emitting");

   a_skip_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !draw_ff) |-> olast_ff)
      else $error("skip result not marked as the last of its entry");
`endif

endmodule

// ----- rtl/core/sprite_list_decoder.sv -----
// One request transaction is taken at a time. A start reads each entry's y word from the RAM
// in turn until it finds the marker or has checked entry 254; the walk then begins at the
// marker's entry, or at entry 255 if there is none. A next reads the code, y and x words of the
// current entry (four RAM reads) and hands them over once the emitter is free, so it can fetch
// while the previous column is emitted; the emitter gives one result per cycle unless stalled.
// Reset clears the sequencer, cursor, parity, result register and screen_flipped, not the RAM.
module sprite_list_decoder (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [9:0]         req_word_address,
   input  logic [15:0]        req_word_value,
   input  logic               req_frame_odd,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_draw,
   output logic [15:0]        rsp_tile_code,
   output logic [4:0]         rsp_colour,
   output logic               rsp_mirror_x,
   output logic               rsp_mirror_y,
   output logic signed [9:0]  rsp_pos_x,
   output logic signed [10:0] rsp_pos_y,
   output logic [7:0]         rsp_pri_mask,
   output logic               rsp_last_of_entry,
   output logic               rsp_list_done,

   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import slc_pkg::*;

   // The only register is screen_flipped at byte address 0. Bit 2 of paddr
   // selects the register; anything at address 4 and up reads as zero and
   // ignores writes.
   logic           screen_flipped_ff, screen_flipped_in;
   logic           csr_write;
   logic           emit_ready;
   entry_desc_type desc;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      screen_flipped_in = screen_flipped_ff;
      if (csr_write && (paddr[2] == CSR_SCREEN_FLIPPED)) begin
         screen_flipped_in = pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_SCREEN_FLIPPED) begin
         prdata = {31'd0, screen_flipped_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_flipped_ff <= 1'b0;
      end else begin
         screen_flipped_ff <= screen_flipped_in;
      end
   end

   // The sequencer owns the sprite RAM. It takes one request transaction at
   // a time, scans for the end marker on a start, and on a next reads the
   // code, y and x words of the current entry before handing them over.
   slc_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_word_address (req_word_address),
      .req_word_value   (req_word_value),
      .req_frame_odd    (req_frame_odd),
      .emit_ready       (emit_ready),
      .desc             (desc)
   );

   // The emitter turns one entry into its column of tile results and holds
   // each one in the result register until the consumer takes it.
   slc_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .screen_flipped    (screen_flipped_ff),
      .desc              (desc),
      .emit_ready        (emit_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_draw          (rsp_draw),
      .rsp_tile_code     (rsp_tile_code),
      .rsp_colour        (rsp_colour),
      .rsp_mirror_x      (rsp_mirror_x),
      .rsp_mirror_y      (rsp_mirror_y),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_pri_mask      (rsp_pri_mask),
      .rsp_last_of_entry (rsp_last_of_entry),
      .rsp_list_done     (rsp_list_done)
   );

endmodule

// ----- tb/sv/tb_sprite_list_decoder.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the sprite list decoder.
//
// A queue of pending request transactions feeds a clocked driver. The driver
// runs the behavioral decoder below on every transaction that it hands over,
// and that decoder queues the tile commands the block should produce. A clocked
// monitor takes each result transaction and compares it, field by field, with
// the oldest queued tile command. Both sides idle at random. The receiver also
// holds off twice for a long stretch, so that the block fills up and stalls
// its request channel.
module tb_sprite_list_decoder;
   import slc_pkg::*;

   // Command code that the block must ignore.
   localparam logic [1:0] CMD_SPARE = 2'd3;

   localparam logic [2:0] FLIP_ADDR     = {CSR_SCREEN_FLIPPED, 2'b00};
   localparam int         SCREEN_PIVOT  = 240;
   // A start scans at most 255 entries, so this covers any work in flight.
   localparam int         SETTLE_CYCLES = 300;
   localparam int         HOLD_CYCLES   = 250;
   localparam int         CYCLE_LIMIT   = 1000000;

   typedef struct packed {
      logic [1:0]  command;
      logic [9:0]  address;
      logic [15:0] value;
      logic        frame_odd;
   } sprite_req_t;

   typedef struct packed {
      logic        draw;
      logic [15:0] tile_code;
      logic [4:0]  colour;
      logic        mirror_x;
      logic        mirror_y;
      logic [9:0]  pos_x;
      logic [10:0] pos_y;
      logic [7:0]  pri_mask;
      logic        last_of_entry;
      logic        list_done;
   } tile_cmd_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_SPARE;
   logic [9:0]  req_word_address = '0;
   logic [15:0] req_word_value = '0;
   logic        req_frame_odd = 1'b0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_draw;
   logic [15:0]        rsp_tile_code;
   logic [4:0]         rsp_colour;
   logic               rsp_mirror_x;
   logic               rsp_mirror_y;
   logic signed [9:0]  rsp_pos_x;
   logic signed [10:0] rsp_pos_y;
   logic [7:0]         rsp_pri_mask;
   logic               rsp_last_of_entry;
   logic               rsp_list_done;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   sprite_list_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_word_address  (req_word_address),
      .req_word_value    (req_word_value),
      .req_frame_odd     (req_frame_odd),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_draw          (rsp_draw),
      .rsp_tile_code     (rsp_tile_code),
      .rsp_colour        (rsp_colour),
      .rsp_mirror_x      (rsp_mirror_x),
      .rsp_mirror_y      (rsp_mirror_y),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_pri_mask      (rsp_pri_mask),
      .rsp_last_of_entry (rsp_last_of_entry),
      .rsp_list_done     (rsp_list_done),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #6 clock = ~clock;

   // Shadow state of the decoder. The store is only ever read where the
   // stimulus has written it first.
   logic [15:0] word_store [0:STORE_WORDS-1];
   logic [7:0]  list_cursor = '0;
   logic        parity_copy = 1'b0;
   logic        list_live = 1'b0;
   logic        flip_copy = 1'b0;

   sprite_req_t req_backlog[$];
   tile_cmd_t   expected_tiles[$];
   sprite_req_t in_flight;
   tile_cmd_t   want;

   int mismatches = 0;
   int cycle_count = 0;
   int req_taken = 0;
   int starts_taken = 0;
   int nexts_taken = 0;
   int tiles_seen = 0;
   int drawn_seen = 0;
   int holds_done = 0;
   int req_gap = 0;
   int req_calm = 0;
   int rsp_calm = 0;
   int stall_left = 0;
   int hold_left = 0;
   int marker_at = -1;

   // Length of the next idle stretch. Most are short and a few are long. Now
   // and then a calm stretch starts, during which this side never idles.
   function automatic int idle_len(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm = $urandom_range(30, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Applies one request to the shadow state and queues the tile commands
   // that it must produce.
   function automatic void predict_tiles(input sprite_req_t r);
      logic [15:0] code, yw, xw, tile;
      logic [8:0]  ym;
      logic [7:0]  pri;
      logic        fx, fy, done;
      int          multi, xs, ys, step, m;
      tile_cmd_t   t;
      t = '0;
      case (r.command)
         CMD_WRITE: begin
            word_store[r.address] = r.value;
         end
         CMD_START: begin
            parity_copy = r.frame_odd;
            list_cursor = NO_MARK_ENTRY;
            list_live = 1'b1;
            for (int e = 0; e <= int'(LAST_SCAN); e++) begin
               if (word_store[{8'(e), OFS_Y}] == END_MARK) begin
                  list_cursor = 8'(e);
                  break;
               end
            end
         end
         CMD_NEXT: begin
            t.last_of_entry = 1'b1;
            if (!list_live) begin
               t.list_done = 1'b1;
               expected_tiles.push_back(t);
            end else begin
               code = word_store[{list_cursor, OFS_CODE}];
               yw = word_store[{list_cursor, OFS_Y}];
               xw = word_store[{list_cursor, OFS_X}];
               done = (list_cursor == 8'd0);
               if (done) list_live = 1'b0;
               else list_cursor = list_cursor - 8'd1;
               if (code == 16'd0 || (yw[Y_FLASH_BIT] && parity_copy)) begin
                  // Empty or blinked-out entry: a single blank result.
                  t.list_done = done;
                  expected_tiles.push_back(t);
               end else begin
                  case (xw[15:14])
                     2'd0: pri = PRI_LOW;
                     2'd1: pri = PRI_MID;
                     default: pri = PRI_HIGH;
                  endcase
                  fx = yw[Y_FLIPX_BIT];
                  fy = yw[Y_FLIPY_BIT];
                  multi = (1 << yw[10:9]) - 1;
                  ym = yw[8:0] - 9'(multi * 16) + Y_ADJUST;
                  xs = SCREEN_PIVOT - int'($signed(xw[8:0]));
                  ys = SCREEN_PIVOT - int'($signed(ym));
                  tile = fy ? code : code + 16'(multi);
                  // A flipped screen undoes the mirroring about the pivot and
                  // inverts both tile flips; the column then grows downward.
                  if (flip_copy) begin
                     xs = SCREEN_PIVOT - xs;
                     ys = SCREEN_PIVOT - ys;
                     fx = !fx;
                     fy = !fy;
                     step = 16;
                  end else begin
                     step = -16;
                  end
                  for (m = multi; m >= 0; m--) begin
                     t.draw = 1'b1;
                     t.tile_code = yw[Y_FLIPY_BIT] ? tile + 16'(m) : tile - 16'(m);
                     t.colour = xw[13:9];
                     t.mirror_x = fx;
                     t.mirror_y = fy;
                     t.pos_x = 10'(xs);
                     t.pos_y = 11'(ys + step * m);
                     t.pri_mask = pri;
                     t.last_of_entry = (m == 0);
                     t.list_done = (m == 0) && done;
                     expected_tiles.push_back(t);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void push_req(input logic [1:0] cmd, input logic [9:0] addr,
                                    input logic [15:0] val, input logic odd);
      sprite_req_t r;
      r.command = cmd;
      r.address = addr;
      r.value = val;
      r.frame_odd = odd;
      req_backlog.push_back(r);
   endfunction

   function automatic void push_start(input logic odd);
      push_req(CMD_START, 10'($urandom), 16'($urandom), odd);
   endfunction

   function automatic void push_next(input int count);
      for (int i = 0; i < count; i++)
         push_req(CMD_NEXT, 10'($urandom), 16'($urandom), 1'($urandom));
   endfunction

   // Any y word except the end marker.
   function automatic logic [15:0] plain_y();
      logic [15:0] v;
      v = 16'($urandom);
      if (v == END_MARK) v = v ^ 16'd1;
      return v;
   endfunction

   // Tile codes lean toward zero (skipped entries) and toward the top of the
   // range, where a tall column wraps around.
   function automatic logic [15:0] rand_code();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'd0;
      if (r < 16) return 16'hfff8 + 16'($urandom_range(0, 7));
      return 16'($urandom);
   endfunction

   // Hand-picked entries 0 to 6 as {code, y word, x word}. Entry 6 carries
   // the end marker.
   function automatic logic [47:0] demo_entry(input int e);
      case (e)
         0: return {16'h0001, 16'h0000, 16'h01ff};  // single tile, x just negative
         1: return {16'h0000, 16'h1234, 16'hffff};  // zero code, skipped
         2: return {16'h0123, 16'h12f0, 16'h7f00};  // flashing pair, x most negative
         3: return {16'hfffc, 16'h47ff, 16'h80ff};  // column of 8 counting up, wraps
         4: return {16'hffff, 16'h2500, 16'hd210};  // column of 4, x flipped
         5: return {16'h8000, 16'h6610, 16'h0000};  // column of 8, both flips
         default: return {16'h00aa, END_MARK, 16'hfe80};
      endcase
   endfunction

   // Drives one register write and reads the value back.
   task automatic write_flip(input logic v);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= FLIP_ADDR;
      pwdata <= 32'(v);
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      while (!pready) @(negedge clock);
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      flip_copy = v;
      @(posedge clock);
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      while (!pready) @(negedge clock);
      if (prdata !== 32'(v)) begin
         $display("%0t: screen_flipped read back expected %0d, got %0d", $time, v, prdata);
         mismatches++;
      end
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Waits until every queued request has been taken and every tile command
   // has come back, then lets any trailing start scan finish.
   task automatic wait_drained();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || expected_tiles.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random frames. Each frame moves the end marker to a new entry, refreshes
   // a few entries below it, starts a list and walks it. Some walks stop early
   // so the next start lands in the middle of a list, some run past the end,
   // and some get a write to an entry still ahead of the cursor. The marker
   // stays among entries 0 to 6, whose words are all written.
   task automatic random_frames(input int quota);
      int made, k, e, walk, poke_at, r;
      made = 0;
      while (made < quota) begin
         k = $urandom_range(0, 6);
         if (marker_at >= 0 && marker_at != k) begin
            push_req(CMD_WRITE, {8'(marker_at), OFS_Y}, plain_y(), 1'($urandom));
            made++;
         end
         for (e = 0; e < k; e++) begin
            if ($urandom_range(0, k) < 3) begin
               push_req(CMD_WRITE, {8'(e), OFS_CODE}, rand_code(), 1'($urandom));
               push_req(CMD_WRITE, {8'(e), OFS_Y}, plain_y(), 1'($urandom));
               push_req(CMD_WRITE, {8'(e), OFS_X}, 16'($urandom), 1'($urandom));
               made += 3;
            end
         end
         push_req(CMD_WRITE, {8'(k), OFS_CODE}, rand_code(), 1'($urandom));
         push_req(CMD_WRITE, {8'(k), OFS_Y}, END_MARK, 1'($urandom));
         push_req(CMD_WRITE, {8'(k), OFS_X}, 16'($urandom), 1'($urandom));
         marker_at = k;
         push_start(1'($urandom));
         made += 4;

         r = $urandom_range(0, 99);
         if (r < 70) walk = k + 1;
         else if (r < 85) walk = k + 1 + $urandom_range(1, 3);
         else walk = $urandom_range(1, k + 1);
         poke_at = ($urandom_range(0, 99) < 15) ? $urandom_range(0, walk - 1) : -1;
         for (e = 0; e < walk; e++) begin
            if (e == poke_at) begin
               push_req(CMD_WRITE,
                        {8'($urandom_range(0, k)), ($urandom_range(0, 1) ? OFS_CODE : OFS_X)},
                        rand_code(), 1'($urandom));
               made++;
            end
            push_next(1);
         end
         made += walk;

         // Noise: an ignored command, and a write to an unused word.
         if ($urandom_range(0, 99) < 8)
            push_req(CMD_SPARE, 10'($urandom), 16'($urandom), 1'($urandom));
         if ($urandom_range(0, 99) < 8) begin
            push_req(CMD_WRITE, {8'($urandom), 2'd3}, 16'($urandom), 1'($urandom));
            made++;
         end
      end
   endtask

   // Request driver. A transaction is taken at an edge where valid is high
   // and stall is low; only then, or while valid is low, does the payload change.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_tiles(in_flight);
            req_taken++;
            if (in_flight.command == CMD_START) starts_taken++;
            if (in_flight.command == CMD_NEXT) nexts_taken++;
            req_gap = idle_len(req_calm);
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               in_flight = req_backlog.pop_front();
               req_valid <= 1'b1;
               req_command <= in_flight.command;
               req_word_address <= in_flight.address;
               req_word_value <= in_flight.value;
               req_frame_odd <= in_flight.frame_odd;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input int exp_v, input int got_v);
      if (exp_v != got_v) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
         mismatches++;
      end
   endtask

   // Result monitor and stall generator. Twice in the run the receiver holds
   // off for a long stretch while requests keep coming.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            tiles_seen++;
            if (rsp_draw) drawn_seen++;
            if (expected_tiles.size() == 0) begin
               $display("%0t: result transaction with no tile command expected", $time);
               mismatches++;
            end else begin
               want = expected_tiles.pop_front();
               check_field("draw", want.draw, rsp_draw);
               check_field("tile_code", want.tile_code, rsp_tile_code);
               check_field("colour", want.colour, rsp_colour);
               check_field("mirror_x", want.mirror_x, rsp_mirror_x);
               check_field("mirror_y", want.mirror_y, rsp_mirror_y);
               check_field("pos_x", int'($signed(want.pos_x)), int'(rsp_pos_x));
               check_field("pos_y", int'($signed(want.pos_y)), int'(rsp_pos_y));
               check_field("pri_mask", want.pri_mask, rsp_pri_mask);
               check_field("last_of_entry", want.last_of_entry, rsp_last_of_entry);
               check_field("list_done", want.list_done, rsp_list_done);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if ((holds_done == 0 && tiles_seen >= 30) ||
                      (holds_done == 1 && tiles_seen >= 80)) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = idle_len(rsp_calm);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_sprite_list_decoder: errors");
         $finish;
      end
   end

   initial begin
      int          a;
      logic [47:0] ent;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // A next before any start has no list to walk.
      push_next(1);

      // Every word that a scan or a decode can reach gets written before any
      // start: the y word of every entry, all words of the hand-picked
      // entries 0 to 6, and all words of entries 254 and 255. All other y
      // words stay clear of the end marker.
      for (a = 0; a < 256; a++) begin
         if (a <= 6) begin
            ent = demo_entry(a);
            push_req(CMD_WRITE, {8'(a), OFS_CODE}, ent[47:32], 1'($urandom));
            push_req(CMD_WRITE, {8'(a), OFS_Y}, ent[31:16], 1'($urandom));
            push_req(CMD_WRITE, {8'(a), OFS_X}, ent[15:0], 1'($urandom));
         end else if (a >= 254) begin
            push_req(CMD_WRITE, {8'(a), OFS_CODE}, rand_code(), 1'($urandom));
            push_req(CMD_WRITE, {8'(a), OFS_Y}, plain_y(), 1'($urandom));
            push_req(CMD_WRITE, {8'(a), OFS_X}, 16'($urandom), 1'($urandom));
         end else begin
            push_req(CMD_WRITE, {8'(a), OFS_Y}, plain_y(), 1'($urandom));
         end
      end
      marker_at = 6;

      // Full walk from the marker down to entry 0 on an even frame, then one
      // more next with the list already finished.
      push_start(1'b0);
      push_next(8);

      // Odd frame: the flashing entry is skipped. Entry 0 gets a zero code
      // while the list is running, so it ends the list as a skipped entry.
      push_start(1'b1);
      push_next(3);
      push_req(CMD_WRITE, {8'd0, OFS_CODE}, 16'd0, 1'b0);
      push_next(4);

      // Restart in the middle of a list, this time with no marker anywhere,
      // so the walk begins at the last entry.
      push_start(1'b0);
      push_next(1);
      push_req(CMD_WRITE, {8'd6, OFS_Y}, plain_y(), 1'b0);
      push_start(1'b1);
      push_next(2);

      // An ignored command, then a marker at the last entry that is scanned.
      push_req(CMD_SPARE, 10'h3ff, 16'hffff, 1'b1);
      push_req(CMD_WRITE, {8'd254, OFS_Y}, END_MARK, 1'b0);
      push_start(1'b0);
      push_next(1);
      marker_at = 254;
      wait_drained();

      // Random phases under both screen orientations.
      write_flip(1'b1);
      random_frames(10);
      wait_drained();
      write_flip(1'b0);
      random_frames(10);
      wait_drained();
      write_flip(1'b1);
      random_frames(10);
      wait_drained();

      $display("Run covered %0d requests: %0d list starts and %0d entry decodes.",
               req_taken, starts_taken, nexts_taken);
      $display("Checked %0d results (%0d tile commands), both screen orientations, %0d long holds.",
               tiles_seen, drawn_seen, holds_done);
      if (mismatches == 0) begin
         $display("tb_sprite_list_decoder: clean");
      end else begin
         $display("tb_sprite_list_decoder: errors");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/slc_pkg.sv
rtl/core/slc_ram.sv
rtl/core/slc_seq.sv
rtl/core/slc_emit.sv
rtl/core/sprite_list_decoder.sv
tb/sv/tb_sprite_list_decoder.sv
